@@ design/nmea_gga_position_parser_macros.svh @@
// ----------------------------------------------------------------------------
// nmea gga position parser assertion macros
// concurrent assertion wrappers clocked on clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH

// same-cycle implication
`define NGGA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NGGA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ngga_pkg.sv @@
// ----------------------------------------------------------------------------
// ngga_pkg
// shared types, character codes and arithmetic constants of the gga parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ngga_pkg;

   localparam int FracDigitsDefault = 5;

   localparam int AccWidth  = 20;
   localparam int LatWidth  = 31;
   localparam int LonWidth  = 32;
   localparam int AltWidth  = 25;
   localparam int SatWidth  = 7;
   localparam int DegWidth  = 14;
   localparam int MinWidth  = 7;
   localparam int TermWidth = 25;
   localparam int AltfWidth = 7;
   localparam int MagWidth  = 37;
   localparam int CmWidth   = 27;

   localparam logic [AccWidth-1:0] AccMax = '1;

   localparam logic [7:0] CharCr    = 8'h0d;
   localparam logic [7:0] CharLf    = 8'h0a;
   localparam logic [7:0] CharComma = 8'h2c;
   localparam logic [7:0] CharPoint = 8'h2e;
   localparam logic [7:0] CharMinus = 8'h2d;
   localparam logic [7:0] CharPlus  = 8'h2b;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharSouth = 8'h53;
   localparam logic [7:0] CharWest  = 8'h57;

   localparam logic [2:0] HeaderLen = 3'd6;

   localparam logic [3:0] FieldLat     = 4'd2;
   localparam logic [3:0] FieldLatHemi = 4'd3;
   localparam logic [3:0] FieldLon     = 4'd4;
   localparam logic [3:0] FieldLonHemi = 4'd5;
   localparam logic [3:0] FieldFix     = 4'd6;
   localparam logic [3:0] FieldSats    = 4'd7;
   localparam logic [3:0] FieldAlt     = 4'd9;
   localparam logic [3:0] FieldMax     = 4'd15;

   localparam longint TenMillion = 64'd10000000;
   localparam longint LatLimit   = 64'd900000000;
   localparam longint LonLimit   = 64'd1800000000;
   localparam longint AltHigh    = 64'd10000000;
   localparam longint AltLowMag  = 64'd1000000;
   localparam logic [SatWidth-1:0] SatMax = 7'd99;

   typedef enum logic [3:0] {
      EV_NONE,
      EV_LAT,
      EV_LON,
      EV_NEG_LAT,
      EV_NEG_LON,
      EV_FIX,
      EV_SATS,
      EV_ALT,
      EV_EMIT
   } ngga_kind_type;

   typedef struct packed {
      ngga_kind_type kind;
      logic          minus;
   } ngga_event_type;

   function automatic longint pow10(input int n);
      longint r;
      r = 1;
      for (int i = 0; i < 8; i++) begin
         if (i < n) begin
            r = r * 10;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h24;
         3'd1:    c = 8'h47;
         3'd2:    c = 8'h50;
         3'd3:    c = 8'h47;
         3'd4:    c = 8'h47;
         3'd5:    c = 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ design/ngga_req_if.sv @@
// ----------------------------------------------------------------------------
// ngga_req_if
// request channel carrying one received byte per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ngga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/ngga_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ngga_rsp_if
// response channel carrying one position report
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ngga_rsp_if;
   import ngga_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [LatWidth-1:0] latitude;
   logic signed [LonWidth-1:0] longitude;
   logic signed [AltWidth-1:0] altitude_cm;
   logic [SatWidth-1:0]        satellites;
   logic                       has_fix;

   modport source (output valid, output latitude, output longitude, output altitude_cm,
                   output satellites, output has_fix, input ready);
   modport sink (input valid, input latitude, input longitude, input altitude_cm,
                 input satellites, input has_fix, output ready);
endinterface

@@ design/ngga_front.sv @@
// ----------------------------------------------------------------------------
// ngga_front
// byte scanner: header match, field split, number accumulation, field events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngga_front #(
   parameter int FRAC_DIGITS = ngga_pkg::FracDigitsDefault,
   localparam int FracWidth = $clog2(ngga_pkg::pow10(FRAC_DIGITS))
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           accept,
   input  logic [7:0]                     rx_byte,
   output ngga_pkg::ngga_event_type       ev_out,
   output logic [ngga_pkg::AccWidth-1:0]  int_out,
   output logic [FracWidth-1:0]           frac_out,
   output logic [2:0]                     count_out
);
   import ngga_pkg::*;

   localparam int FracMacWidth = FracWidth + 4;
   localparam int IntMacWidth  = AccWidth + 4;
   localparam logic [2:0] FracCount = 3'(FRAC_DIGITS);

   logic [2:0]             hdr_pos_ff, hdr_pos_in;
   logic                   hdr_bad_ff, hdr_bad_in;
   logic [3:0]             field_ff, field_in;
   logic [AccWidth-1:0]    int_ff, int_in;
   logic [FracWidth-1:0]   frac_ff, frac_in;
   logic [2:0]             count_ff, count_in;
   logic                   point_ff, point_in;
   logic                   stop_ff, stop_in;
   logic                   minus_ff, minus_in;
   logic                   nonempty_ff, nonempty_in;
   logic                   lat_fresh_ff, lat_fresh_in;
   logic                   lon_fresh_ff, lon_fresh_in;
   ngga_event_type         ev_ff, ev_in;
   logic [AccWidth-1:0]    int_ev_ff;
   logic [FracWidth-1:0]   frac_ev_ff;
   logic [2:0]             count_ev_ff;

   ngga_kind_type          kind;
   logic                   matched;
   logic                   is_digit;
   logic [3:0]             digit;
   logic [IntMacWidth-1:0] int_mac;
   logic [FracMacWidth-1:0] frac_mac;

   assign matched  = (hdr_pos_ff == HeaderLen) && !hdr_bad_ff;
   assign is_digit = (rx_byte >= CharZero) && (rx_byte <= CharNine);
   assign digit    = 4'(rx_byte - CharZero);
   assign int_mac  = IntMacWidth'(int_ff) * IntMacWidth'(10) + IntMacWidth'(digit);
   assign frac_mac = FracMacWidth'(frac_ff) * FracMacWidth'(10) + FracMacWidth'(digit);

   always_comb begin
      hdr_pos_in   = hdr_pos_ff;
      hdr_bad_in   = hdr_bad_ff;
      field_in     = field_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      count_in     = count_ff;
      point_in     = point_ff;
      stop_in      = stop_ff;
      minus_in     = minus_ff;
      nonempty_in  = nonempty_ff;
      lat_fresh_in = lat_fresh_ff;
      lon_fresh_in = lon_fresh_ff;
      kind         = EV_NONE;

      if (accept && (rx_byte != CharCr)) begin
         if (rx_byte == CharLf) begin
            if (matched) begin
               kind = EV_EMIT;
            end
            hdr_pos_in   = '0;
            hdr_bad_in   = 1'b0;
            field_in     = '0;
            int_in       = '0;
            frac_in      = '0;
            count_in     = '0;
            point_in     = 1'b0;
            stop_in      = 1'b0;
            minus_in     = 1'b0;
            nonempty_in  = 1'b0;
            lat_fresh_in = 1'b0;
            lon_fresh_in = 1'b0;
         end else begin
            if ((hdr_pos_ff < HeaderLen) && !hdr_bad_ff) begin
               if (rx_byte == header_char(hdr_pos_ff)) begin
                  hdr_pos_in = hdr_pos_ff + 3'd1;
               end else begin
                  hdr_bad_in = 1'b1;
               end
            end
            if (rx_byte == CharComma) begin
               if (matched) begin
                  case (field_ff)
                     FieldLat: begin
                        if (nonempty_ff) begin
                           kind         = EV_LAT;
                           lat_fresh_in = 1'b1;
                        end
                     end
                     FieldLatHemi: begin
                        if (nonempty_ff && (int_ff == AccWidth'(CharSouth)) && lat_fresh_ff) begin
                           kind = EV_NEG_LAT;
                        end
                     end
                     FieldLon: begin
                        if (nonempty_ff) begin
                           kind         = EV_LON;
                           lon_fresh_in = 1'b1;
                        end
                     end
                     FieldLonHemi: begin
                        if (nonempty_ff && (int_ff == AccWidth'(CharWest)) && lon_fresh_ff) begin
                           kind = EV_NEG_LON;
                        end
                     end
                     FieldFix: begin
                        if (nonempty_ff) begin
                           kind = EV_FIX;
                        end
                     end
                     FieldSats: begin
                        if (nonempty_ff) begin
                           kind = EV_SATS;
                        end
                     end
                     FieldAlt: begin
                        if (nonempty_ff) begin
                           kind = EV_ALT;
                        end
                     end
                     default: begin
                        kind = EV_NONE;
                     end
                  endcase
               end
               if (field_ff != FieldMax) begin
                  field_in = field_ff + 4'd1;
               end
               int_in      = '0;
               frac_in     = '0;
               count_in    = '0;
               point_in    = 1'b0;
               stop_in     = 1'b0;
               minus_in    = 1'b0;
               nonempty_in = 1'b0;
            end else if ((field_ff == FieldLatHemi) || (field_ff == FieldLonHemi)) begin
               int_in      = nonempty_ff ? AccMax : AccWidth'(rx_byte);
               nonempty_in = 1'b1;
            end else begin
               if (is_digit) begin
                  if (!point_ff && !stop_ff) begin
                     int_in = (int_mac > IntMacWidth'(AccMax)) ? AccMax
                                                               : int_mac[AccWidth-1:0];
                  end else if (point_ff && !stop_ff && (count_ff < FracCount)) begin
                     frac_in  = frac_mac[FracWidth-1:0];
                     count_in = count_ff + 3'd1;
                  end
               end else if ((rx_byte == CharPoint) && !point_ff && !stop_ff) begin
                  point_in = 1'b1;
               end else if ((rx_byte == CharMinus) && !nonempty_ff) begin
                  minus_in = 1'b1;
               end else if (!((rx_byte == CharPlus) && !nonempty_ff)) begin
                  stop_in = 1'b1;
               end
               nonempty_in = 1'b1;
            end
         end
      end

      ev_in.kind  = kind;
      ev_in.minus = minus_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff   <= '0;
         hdr_bad_ff   <= 1'b0;
         field_ff     <= '0;
         int_ff       <= '0;
         frac_ff      <= '0;
         count_ff     <= '0;
         point_ff     <= 1'b0;
         stop_ff      <= 1'b0;
         minus_ff     <= 1'b0;
         nonempty_ff  <= 1'b0;
         lat_fresh_ff <= 1'b0;
         lon_fresh_ff <= 1'b0;
         ev_ff        <= '{kind: EV_NONE, minus: 1'b0};
      end else begin
         hdr_pos_ff   <= hdr_pos_in;
         hdr_bad_ff   <= hdr_bad_in;
         field_ff     <= field_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         count_ff     <= count_in;
         point_ff     <= point_in;
         stop_ff      <= stop_in;
         minus_ff     <= minus_in;
         nonempty_ff  <= nonempty_in;
         lat_fresh_ff <= lat_fresh_in;
         lon_fresh_ff <= lon_fresh_in;
         if (advance) begin
            ev_ff <= ev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         int_ev_ff   <= int_ff;
         frac_ev_ff  <= frac_ff;
         count_ev_ff <= count_ff;
      end
   end

   assign ev_out    = ev_ff;
   assign int_out   = int_ev_ff;
   assign frac_out  = frac_ev_ff;
   assign count_out = count_ev_ff;

endmodule

@@ design/ngga_calc.sv @@
// ----------------------------------------------------------------------------
// ngga_calc
// six-stage fixed point pipeline: fraction scaling, degree/minute split,
// minutes to degree rounding, centimetre rounding, final sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngga_calc #(
   parameter int FRAC_DIGITS = ngga_pkg::FracDigitsDefault,
   localparam int FracWidth = $clog2(ngga_pkg::pow10(FRAC_DIGITS))
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  ngga_pkg::ngga_event_type       ev_in,
   input  logic [ngga_pkg::AccWidth-1:0]  int_in,
   input  logic [FracWidth-1:0]           frac_in,
   input  logic [2:0]                     count_in,
   output ngga_pkg::ngga_event_type       ev_out,
   output logic [ngga_pkg::AccWidth-1:0]  int_out,
   output logic [ngga_pkg::MagWidth-1:0]  mag_out,
   output logic [ngga_pkg::CmWidth-1:0]   cm_out
);
   import ngga_pkg::*;

   localparam longint FracScale  = pow10(FRAC_DIGITS);
   localparam longint MinScale   = pow10(7 - FRAC_DIGITS);
   localparam int     ScaleWidth = FracWidth + 1;

   localparam longint R100       = (longint'(1) << AccWidth) / 100;
   localparam int     R100Width  = $clog2(R100 + 1);

   localparam int     V60Width   = 30;
   localparam longint R60        = (longint'(1) << V60Width) / 60;
   localparam int     R60Width   = $clog2(R60 + 1);

   localparam int     ValtWidth  = $clog2(100 * FracScale + FracScale / 2 + 1);
   localparam longint RAlt       = (longint'(1) << ValtWidth) / FracScale;
   localparam int     RAltWidth  = $clog2(RAlt + 1);

   // stage 1
   logic [ScaleWidth-1:0]             scale;
   logic [FracWidth+ScaleWidth-1:0]   fn_prod;
   logic [AccWidth+R100Width-1:0]     q100_prod;
   ngga_event_type                    ev1_ff;
   logic [AccWidth-1:0]               int1_ff;
   logic [DegWidth-1:0]               q100_1_ff;
   logic [FracWidth-1:0]              fn1_ff;

   // stage 2
   logic [AccWidth:0]                 rem100;
   logic [DegWidth-1:0]               deg_in;
   logic [MinWidth-1:0]               min_in;
   ngga_event_type                    ev2_ff;
   logic [AccWidth-1:0]               int2_ff;
   logic [DegWidth-1:0]               deg2_ff;
   logic [MinWidth-1:0]               min2_ff;
   logic [FracWidth-1:0]              fn2_ff;

   // stage 3
   ngga_event_type                    ev3_ff;
   logic [AccWidth-1:0]               int3_ff;
   logic [DegWidth-1:0]               deg3_ff;
   logic [V60Width-1:0]               v60_3_ff;
   logic [ValtWidth-1:0]              valt3_ff;

   // stage 4
   logic [V60Width+R60Width-1:0]      q60_prod;
   logic [ValtWidth+RAltWidth-1:0]    qalt_prod;
   ngga_event_type                    ev4_ff;
   logic [AccWidth-1:0]               int4_ff;
   logic [DegWidth-1:0]               deg4_ff;
   logic [V60Width-1:0]               v60_4_ff;
   logic [ValtWidth-1:0]              valt4_ff;
   logic [TermWidth-1:0]              q60_4_ff;
   logic [AltfWidth-1:0]              qalt4_ff;

   // stage 5
   logic [V60Width-1:0]               rem60;
   logic [ValtWidth-1:0]              remalt;
   ngga_event_type                    ev5_ff;
   logic [AccWidth-1:0]               int5_ff;
   logic [DegWidth-1:0]               deg5_ff;
   logic [TermWidth-1:0]              term5_ff;
   logic [AltfWidth-1:0]              altf5_ff;

   // stage 6
   ngga_event_type                    ev6_ff;
   logic [AccWidth-1:0]               int6_ff;
   logic [MagWidth-1:0]               mag6_ff;
   logic [CmWidth-1:0]                cm6_ff;

   // fraction normalized to full digit count
   always_comb begin
      case (count_in)
         3'd0:    scale = ScaleWidth'(pow10(FRAC_DIGITS));
         3'd1:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 1));
         3'd2:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 2));
         3'd3:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 3));
         3'd4:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 4));
         3'd5:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 5));
         3'd6:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 6));
         3'd7:    scale = ScaleWidth'(pow10(FRAC_DIGITS - 7));
         default: scale = ScaleWidth'(1);
      endcase
   end

   assign fn_prod   = (FracWidth + ScaleWidth)'(frac_in) * (FracWidth + ScaleWidth)'(scale);
   assign q100_prod = (AccWidth + R100Width)'(int_in) * (AccWidth + R100Width)'(R100);

   // quotient estimate is exact or one low
   assign rem100 = (AccWidth + 1)'(int1_ff) - (AccWidth + 1)'(longint'(q100_1_ff) * 100);

   always_comb begin
      if (rem100 >= (AccWidth + 1)'(100)) begin
         deg_in = q100_1_ff + DegWidth'(1);
         min_in = MinWidth'(rem100 - (AccWidth + 1)'(100));
      end else begin
         deg_in = q100_1_ff;
         min_in = MinWidth'(rem100);
      end
   end

   assign q60_prod  = (V60Width + R60Width)'(v60_3_ff) * (V60Width + R60Width)'(R60);
   assign qalt_prod = (ValtWidth + RAltWidth)'(valt3_ff) * (ValtWidth + RAltWidth)'(RAlt);

   assign rem60  = v60_4_ff - V60Width'(longint'(q60_4_ff) * 60);
   assign remalt = valt4_ff - ValtWidth'(longint'(qalt4_ff) * FracScale);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev1_ff <= '{kind: EV_NONE, minus: 1'b0};
         ev2_ff <= '{kind: EV_NONE, minus: 1'b0};
         ev3_ff <= '{kind: EV_NONE, minus: 1'b0};
         ev4_ff <= '{kind: EV_NONE, minus: 1'b0};
         ev5_ff <= '{kind: EV_NONE, minus: 1'b0};
         ev6_ff <= '{kind: EV_NONE, minus: 1'b0};
      end else if (advance) begin
         ev1_ff <= ev_in;
         ev2_ff <= ev1_ff;
         ev3_ff <= ev2_ff;
         ev4_ff <= ev3_ff;
         ev5_ff <= ev4_ff;
         ev6_ff <= ev5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         int1_ff   <= int_in;
         q100_1_ff <= q100_prod[AccWidth +: DegWidth];
         fn1_ff    <= fn_prod[FracWidth-1:0];

         int2_ff   <= int1_ff;
         deg2_ff   <= deg_in;
         min2_ff   <= min_in;
         fn2_ff    <= fn1_ff;

         int3_ff   <= int2_ff;
         deg3_ff   <= deg2_ff;
         v60_3_ff  <= V60Width'(longint'(min2_ff) * TenMillion
                               + longint'(fn2_ff) * MinScale + 30);
         valt3_ff  <= ValtWidth'(longint'(fn2_ff) * 100 + FracScale / 2);

         int4_ff   <= int3_ff;
         deg4_ff   <= deg3_ff;
         v60_4_ff  <= v60_3_ff;
         valt4_ff  <= valt3_ff;
         q60_4_ff  <= q60_prod[V60Width +: TermWidth];
         qalt4_ff  <= qalt_prod[ValtWidth +: AltfWidth];

         int5_ff   <= int4_ff;
         deg5_ff   <= deg4_ff;
         term5_ff  <= (rem60 >= V60Width'(60)) ? q60_4_ff + TermWidth'(1) : q60_4_ff;
         altf5_ff  <= (remalt >= ValtWidth'(FracScale)) ? qalt4_ff + AltfWidth'(1) : qalt4_ff;

         int6_ff   <= int5_ff;
         mag6_ff   <= MagWidth'(longint'(deg5_ff) * TenMillion + longint'(term5_ff));
         cm6_ff    <= CmWidth'(longint'(int5_ff) * 100 + longint'(altf5_ff));
      end
   end

   assign ev_out  = ev6_ff;
   assign int_out = int6_ff;
   assign mag_out = mag6_ff;
   assign cm_out  = cm6_ff;

endmodule

@@ design/ngga_hold.sv @@
// ----------------------------------------------------------------------------
// ngga_hold
// held location registers, saturation and sign, response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngga_hold (
   input  logic                           clock,
   input  logic                           reset,
   input  ngga_pkg::ngga_event_type       ev_in,
   input  logic [ngga_pkg::AccWidth-1:0]  int_in,
   input  logic [ngga_pkg::MagWidth-1:0]  mag_in,
   input  logic [ngga_pkg::CmWidth-1:0]   cm_in,
   output logic                           advance,
   ngga_rsp_if.source                     rsp_port
);
   import ngga_pkg::*;

   logic signed [LatWidth-1:0] lat_ff, lat_in;
   logic signed [LonWidth-1:0] lon_ff, lon_in;
   logic signed [AltWidth-1:0] alt_ff, alt_in;
   logic [SatWidth-1:0]        sat_ff, sat_in;
   logic                       fix_ff, fix_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [LatWidth-1:0] rsp_lat_ff, rsp_lat_in;
   logic signed [LonWidth-1:0] rsp_lon_ff, rsp_lon_in;
   logic signed [AltWidth-1:0] rsp_alt_ff, rsp_alt_in;
   logic [SatWidth-1:0]        rsp_sat_ff, rsp_sat_in;
   logic                       rsp_fix_ff, rsp_fix_in;

   logic [LatWidth-1:0]        lat_mag;
   logic [LonWidth-2:0]        lon_mag;
   logic [CmWidth-1:0]         alt_mag;

   assign advance = !((ev_in.kind == EV_EMIT) && rsp_valid_ff && !rsp_port.ready);

   assign lat_mag = (mag_in > MagWidth'(LatLimit)) ? LatWidth'(LatLimit)
                                                   : mag_in[LatWidth-1:0];
   assign lon_mag = (mag_in > MagWidth'(LonLimit)) ? (LonWidth - 1)'(LonLimit)
                                                   : mag_in[LonWidth-2:0];

   always_comb begin
      if (ev_in.minus) begin
         alt_mag = (cm_in > CmWidth'(AltLowMag)) ? CmWidth'(AltLowMag) : cm_in;
      end else begin
         alt_mag = (cm_in > CmWidth'(AltHigh)) ? CmWidth'(AltHigh) : cm_in;
      end
   end

   always_comb begin
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      alt_in       = alt_ff;
      sat_in       = sat_ff;
      fix_in       = fix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_lat_in   = rsp_lat_ff;
      rsp_lon_in   = rsp_lon_ff;
      rsp_alt_in   = rsp_alt_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_fix_in   = rsp_fix_ff;
      if (advance) begin
         case (ev_in.kind)
            EV_LAT: begin
               lat_in = ev_in.minus ? LatWidth'(0) - lat_mag : lat_mag;
            end
            EV_LON: begin
               lon_in = ev_in.minus ? LonWidth'(0) - {1'b0, lon_mag} : {1'b0, lon_mag};
            end
            EV_NEG_LAT: begin
               lat_in = -lat_ff;
            end
            EV_NEG_LON: begin
               lon_in = -lon_ff;
            end
            EV_FIX: begin
               fix_in = !ev_in.minus && (int_in != '0);
            end
            EV_SATS: begin
               if (ev_in.minus) begin
                  sat_in = '0;
               end else if (int_in > AccWidth'(SatMax)) begin
                  sat_in = SatMax;
               end else begin
                  sat_in = int_in[SatWidth-1:0];
               end
            end
            EV_ALT: begin
               alt_in = ev_in.minus ? AltWidth'(0) - alt_mag[AltWidth-1:0]
                                    : alt_mag[AltWidth-1:0];
            end
            EV_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_lat_in   = lat_ff;
               rsp_lon_in   = lon_ff;
               rsp_alt_in   = alt_ff;
               rsp_sat_in   = sat_ff;
               rsp_fix_in   = fix_ff;
            end
            default: begin
               lat_in = lat_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff       <= '0;
         lon_ff       <= '0;
         alt_ff       <= '0;
         sat_ff       <= '0;
         fix_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         alt_ff       <= alt_in;
         sat_ff       <= sat_in;
         fix_ff       <= fix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_lat_ff <= rsp_lat_in;
      rsp_lon_ff <= rsp_lon_in;
      rsp_alt_ff <= rsp_alt_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_fix_ff <= rsp_fix_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.latitude    = rsp_lat_ff;
   assign rsp_port.longitude   = rsp_lon_ff;
   assign rsp_port.altitude_cm = rsp_alt_ff;
   assign rsp_port.satellites  = rsp_sat_ff;
   assign rsp_port.has_fix     = rsp_fix_ff;

endmodule

@@ design/nmea_gga_position_parser.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_position_parser: one byte per request, one request per cycle when not
// stalled; a report passes the front event register, six calc stages and the
// response register; the pipeline stalls only while a report waits there and another
// is due; synchronous reset clears all line state and the held location to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nmea_gga_position_parser_macros.svh"

module nmea_gga_position_parser #(
   parameter int FRAC_DIGITS = ngga_pkg::FracDigitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   ngga_req_if.sink   req_port,
   ngga_rsp_if.source rsp_port
);
   import ngga_pkg::*;

   localparam int FracWidth = $clog2(pow10(FRAC_DIGITS));

   logic                  advance;
   logic                  accept;
   ngga_event_type        front_ev;
   logic [AccWidth-1:0]   front_int;
   logic [FracWidth-1:0]  front_frac;
   logic [2:0]            front_count;
   ngga_event_type        calc_ev;
   logic [AccWidth-1:0]   calc_int;
   logic [MagWidth-1:0]   calc_mag;
   logic [CmWidth-1:0]    calc_cm;

   assign req_port.ready = advance && !reset;
   assign accept         = req_port.valid && req_port.ready;

   ngga_front #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .rx_byte   (req_port.rx_byte),
      .ev_out    (front_ev),
      .int_out   (front_int),
      .frac_out  (front_frac),
      .count_out (front_count)
   );

   ngga_calc #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_calc (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ev_in    (front_ev),
      .int_in   (front_int),
      .frac_in  (front_frac),
      .count_in (front_count),
      .ev_out   (calc_ev),
      .int_out  (calc_int),
      .mag_out  (calc_mag),
      .cm_out   (calc_cm)
   );

   ngga_hold u_hold (
      .clock    (clock),
      .reset    (reset),
      .ev_in    (calc_ev),
      .int_in   (calc_int),
      .mag_in   (calc_mag),
      .cm_in    (calc_cm),
      .advance  (advance),
      .rsp_port (rsp_port)
   );

   `NGGA_ASSERT_NOW(a_stall_cause, !advance, rsp_port.valid && !rsp_port.ready, "stall without blocked response")
   `NGGA_ASSERT_NOW(a_sats_range, rsp_port.valid, rsp_port.satellites <= SatMax, "satellites above limit")
   `NGGA_ASSERT_NEXT(a_cr_dropped, accept && (req_port.rx_byte == CharCr), front_ev.kind == EV_NONE, "carriage return made an event")
   `NGGA_ASSERT_NOW(a_rsp_source, $rose(rsp_port.valid), $past(calc_ev.kind == EV_EMIT), "response without emit event")

endmodule
